### src/cgo_pkg.sv
// Package for the cavity grid occupancy block: grid sizes, command codes, shared types.
// No dependencies.
package cgo_pkg;
    localparam int CellsX = 16;
    localparam int CellsY = 16;
    localparam int CellsZ = 16;
    localparam int CountWidth = 8;
    localparam int NCells = CellsX * CellsY * CellsZ;
    localparam int CellBits = $clog2(NCells);
    localparam int XBits = (CellsX > 1) ? $clog2(CellsX) : 1;
    localparam int YBits = (CellsY > 1) ? $clog2(CellsY) : 1;
    localparam int ZBits = (CellsZ > 1) ? $clog2(CellsZ) : 1;
    localparam int TotalWidth = 13;
    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};

    typedef enum logic [3:0] {
        K_CLEAR   = 4'd0,
        K_ADD     = 4'd1,
        K_REMOVE  = 4'd2,
        K_FILLED  = 4'd3,
        K_FREED   = 4'd4,
        K_SAVE    = 4'd5,
        K_RESTORE = 4'd6,
        K_REBUILD = 4'd7,
        K_QUERY   = 4'd8
    } t_kind;

    // Register indexes on the configuration port.
    localparam logic [2:0] R_BOX_X  = 3'd0;
    localparam logic [2:0] R_BOX_Y  = 3'd1;
    localparam logic [2:0] R_BOX_Z  = 3'd2;
    localparam logic [2:0] R_CELL_X = 3'd3;
    localparam logic [2:0] R_CELL_Y = 3'd4;
    localparam logic [2:0] R_CELL_Z = 3'd5;
    localparam logic [2:0] R_CUTOFF = 3'd6;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       start;     // latch the item, reset the cell counter
        logic       step;      // advance one cell
        logic       pipe_in;   // a cell enters the hit pipeline
        logic       write_en;  // write back the cell at the pipeline end
        logic       finish;    // load the result register
    } t_cmd;

    typedef struct packed {
        logic       last_cell;
    } t_status;
endpackage

### src/cgo_if.sv
// Valid/ready channel interfaces for the cavity grid block.
// No dependencies.
interface cgo_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic signed [31:0] atom_x;
    logic signed [31:0] atom_y;
    logic signed [31:0] atom_z;
    logic [11:0] query_cell;
    modport source (output valid, kind, atom_x, atom_y, atom_z, query_cell, input ready);
    modport sink (input valid, kind, atom_x, atom_y, atom_z, query_cell, output ready);
endinterface

interface cgo_rsp_if;
    logic        valid;
    logic        ready;
    logic        underflow_error;
    logic        overflow_error;
    logic [12:0] cavity_count;
    logic [7:0]  cell_count;
    logic        cell_is_cavity;
    modport source (output valid, underflow_error, overflow_error, cavity_count, cell_count,
                    cell_is_cavity, input ready);
    modport sink (input valid, underflow_error, overflow_error, cavity_count, cell_count,
                  cell_is_cavity, output ready);
endinterface

### src/cgo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module cgo_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### src/cgo_ctrl.sv
// Controller for the cavity grid block: request handshake and the cell sweep sequence.
// Depends on cgo_pkg.
module cgo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic              i_init_done,
    input  cgo_pkg::t_status  i_status,
    output cgo_pkg::t_cmd     o_cmd
);
    // Pipeline depth from cell index to write back: three compute stages, the memory
    // read, then the write back stage.
    localparam int Lat = 5;

    typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DRAIN, S_DONE} t_state;
    t_state r_state, n_state;
    logic [2:0] r_drain, n_drain;
    logic r_out_valid, n_out_valid;
    logic [Lat-1:0] r_pipe, n_pipe;

    assign o_in_ready  = (r_state == S_IDLE) && i_init_done && !r_out_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_drain     = r_drain;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.start = 1'b1;
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                o_cmd.pipe_in = 1'b1;
                o_cmd.step    = 1'b1;
                if (i_status.last_cell) begin
                    n_state = S_DRAIN;
                    n_drain = 3'(Lat);
                end
            end
            S_DRAIN: begin
                n_drain = r_drain - 3'd1;
                if (r_drain == 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        n_pipe = {r_pipe[Lat-2:0], o_cmd.pipe_in};
        o_cmd.write_en = r_pipe[Lat-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_drain     <= '0;
            r_out_valid <= 1'b0;
            r_pipe      <= '0;
        end else begin
            r_state     <= n_state;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
            r_pipe      <= n_pipe;
        end
    end
endmodule

### src/cgo_dp.sv
// Datapath for the cavity grid block: cell geometry pipeline, counter and flag memories.
// Depends on cgo_pkg and cgo_ram.
module cgo_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cgo_pkg::t_cmd      i_cmd,
    output cgo_pkg::t_status   o_status,
    output logic               o_init_done,
    input  logic [3:0]         i_kind,
    input  logic signed [31:0] i_atom_x,
    input  logic signed [31:0] i_atom_y,
    input  logic signed [31:0] i_atom_z,
    input  logic [11:0]        i_query_cell,
    input  logic signed [31:0] i_box_x,
    input  logic signed [31:0] i_box_y,
    input  logic signed [31:0] i_box_z,
    input  logic [30:0]        i_cell_x,
    input  logic [30:0]        i_cell_y,
    input  logic [30:0]        i_cell_z,
    input  logic [30:0]        i_cutoff,
    output logic               o_underflow,
    output logic               o_overflow,
    output logic [12:0]        o_cavity_count,
    output logic [7:0]         o_cell_count,
    output logic               o_cell_is_cavity
);
    localparam int CB = cgo_pkg::CellBits;
    localparam int CW = cgo_pkg::CountWidth;
    localparam int EW = CW + 1; // counter and flag in one word

    // Clearing pass after reset.
    logic [CB:0] r_init;
    logic r_init_done;
    assign o_init_done = r_init_done;

    // Latched item.
    logic [3:0] r_kind;
    logic signed [33:0] r_ax, r_ay, r_az;
    logic [11:0] r_q;

    // Cell walk: flat index and per-axis centres tracked by addition.
    // A centre reaches 15.5 cell edges past the box corner (31 in the doubled units), hence the width.
    logic [CB-1:0] r_cell;
    logic [cgo_pkg::XBits-1:0] r_ix;
    logic [cgo_pkg::YBits-1:0] r_iy;
    logic [cgo_pkg::ZBits-1:0] r_iz;
    logic signed [38:0] r_cx, r_cy, r_cz;

    logic r_unf, r_ovf;
    logic [12:0] r_total, r_saved_total, r_count;

    assign o_status.last_cell = (r_cell == CB'(cgo_pkg::NCells - 1));

    // Doubled box lengths and cutoff.
    logic [40:0] w_lx, w_ly, w_lz;
    logic [31:0] w_r2;
    assign w_lx = 41'(cgo_pkg::CellsX) * {9'd0, i_cell_x, 1'b0};
    assign w_ly = 41'(cgo_pkg::CellsY) * {9'd0, i_cell_y, 1'b0};
    assign w_lz = 41'(cgo_pkg::CellsZ) * {9'd0, i_cell_z, 1'b0};
    assign w_r2 = {i_cutoff, 1'b0};

    function automatic logic [41:0] fold(input logic signed [34:0] a,
                                         input logic signed [38:0] c,
                                         input logic [40:0] len);
        logic signed [39:0] d;
        logic [41:0] ad;
        begin
            d  = 40'(a) - 40'(c);
            ad = d[39] ? 42'(-d) : 42'(d);
            if ({ad, 1'b0} > 43'(len)) begin
                ad = (ad > 42'(len)) ? ad - 42'(len) : 42'(len) - ad;
            end
            fold = ad;
        end
    endfunction

    // Stage 1: fold distances.
    logic [41:0] s1_fx, s1_fy, s1_fz;
    logic [CB-1:0] s1_cell;
    // Stage 2: range check, squares.
    logic s2_ok;
    logic [63:0] s2_sx, s2_sy, s2_sz;
    logic [CB-1:0] s2_cell;
    // Stage 3: sum and compare.
    logic s3_hit;
    logic [CB-1:0] s3_cell;
    logic [63:0] w_lim;
    logic [65:0] w_sum;
    assign w_lim = 64'(w_r2) * 64'(w_r2);
    assign w_sum = 66'(s2_sx) + 66'(s2_sy) + 66'(s2_sz);

    // Stage 4 issues the memory read; stage 5 sees its data and writes back.
    logic s4_hit;
    logic [CB-1:0] s4_cell, s5_cell;
    logic s5_hit;

    // Memories: live grid and snapshot.
    logic          w_we, w_swe;
    logic [CB-1:0] w_waddr, w_raddr;
    logic [EW-1:0] w_wdata, w_rdata, w_sdata;
    logic [CB-1:0] w_saddr;
    logic [EW-1:0] w_swdata;

    cgo_ram #(.Width(EW), .Depth(cgo_pkg::NCells)) u_live (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    cgo_ram #(.Width(EW), .Depth(cgo_pkg::NCells)) u_snap (
        .i_clk(i_clk), .i_we(w_swe), .i_waddr(w_saddr), .i_wdata(w_swdata),
        .i_raddr(w_raddr), .o_rdata(w_sdata));

    // Reads are issued one stage ahead of the write back so values line up at s5.
    assign w_raddr = s4_cell;
    assign w_waddr = r_init_done ? s5_cell : r_init[CB-1:0];
    assign w_saddr = w_waddr;

    logic [CW-1:0] w_cnt;
    logic w_flag;
    assign w_cnt  = w_rdata[CW:1];
    assign w_flag = w_rdata[0];

    logic [CW-1:0] n_cnt;
    logic n_flag, n_unf, n_ovf, w_qhit;
    always_comb begin
        n_cnt  = w_cnt;
        n_flag = w_flag;
        n_unf  = 1'b0;
        n_ovf  = 1'b0;
        w_swe  = 1'b0;
        w_swdata = w_rdata;
        case (r_kind)
            cgo_pkg::K_CLEAR: begin
                n_cnt = '0;
                n_flag = 1'b0;
            end
            cgo_pkg::K_ADD: begin
                if (s5_hit) begin
                    if (w_cnt == cgo_pkg::CountMax) n_ovf = 1'b1;
                    else n_cnt = w_cnt + CW'(1);
                end
            end
            cgo_pkg::K_REMOVE: begin
                if (s5_hit) begin
                    if (w_cnt == '0) n_unf = 1'b1;
                    else n_cnt = w_cnt - CW'(1);
                end
            end
            cgo_pkg::K_FILLED: if (w_cnt != '0) n_flag = 1'b0;
            cgo_pkg::K_FREED: if (w_cnt == '0) n_flag = 1'b1;
            cgo_pkg::K_SAVE: w_swe = i_cmd.write_en;
            cgo_pkg::K_RESTORE: begin
                n_cnt  = w_sdata[CW:1];
                n_flag = w_sdata[0];
            end
            cgo_pkg::K_REBUILD: n_flag = (w_cnt == '0);
            default: ;
        endcase
        if (!r_init_done) begin
            w_swe = 1'b1;
            w_swdata = '0;
        end
        w_we    = !r_init_done || i_cmd.write_en;
        w_wdata = r_init_done ? {n_cnt, n_flag} : '0;
        w_qhit  = (r_kind == cgo_pkg::K_QUERY) && ({1'b0, r_q} < 13'(cgo_pkg::NCells))
                  && (13'(s5_cell) == {1'b0, r_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init      <= '0;
            r_init_done <= 1'b0;
            r_total     <= '0;
            r_saved_total <= '0;
        end else begin
            if (!r_init_done) begin
                r_init <= r_init + (CB+1)'(1);
                if (r_init == (CB+1)'(cgo_pkg::NCells - 1)) r_init_done <= 1'b1;
            end
            if (i_cmd.finish) begin
                case (r_kind)
                    cgo_pkg::K_CLEAR:   r_total <= '0;
                    cgo_pkg::K_SAVE:    r_saved_total <= r_total;
                    cgo_pkg::K_RESTORE: r_total <= r_saved_total;
                    cgo_pkg::K_REBUILD: r_total <= r_count;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_kind <= i_kind;
            r_ax <= 34'(i_atom_x) <<< 1;
            r_ay <= 34'(i_atom_y) <<< 1;
            r_az <= 34'(i_atom_z) <<< 1;
            r_q  <= i_query_cell;
            r_cell <= '0;
            r_ix <= '0; r_iy <= '0; r_iz <= '0;
            r_cx <= (39'(i_box_x) <<< 1) + 39'(i_cell_x);
            r_cy <= (39'(i_box_y) <<< 1) + 39'(i_cell_y);
            r_cz <= (39'(i_box_z) <<< 1) + 39'(i_cell_z);
            r_unf <= 1'b0;
            r_ovf <= 1'b0;
            r_count <= '0;
            o_cell_count <= '0;
            o_cell_is_cavity <= 1'b0;
        end else if (i_cmd.step) begin
            r_cell <= r_cell + CB'(1);
            if (r_iz == cgo_pkg::ZBits'(cgo_pkg::CellsZ - 1)) begin
                r_iz <= '0;
                r_cz <= (39'(i_box_z) <<< 1) + 39'(i_cell_z);
                if (r_iy == cgo_pkg::YBits'(cgo_pkg::CellsY - 1)) begin
                    r_iy <= '0;
                    r_cy <= (39'(i_box_y) <<< 1) + 39'(i_cell_y);
                    r_ix <= r_ix + cgo_pkg::XBits'(1);
                    r_cx <= r_cx + 39'({i_cell_x, 1'b0});
                end else begin
                    r_iy <= r_iy + cgo_pkg::YBits'(1);
                    r_cy <= r_cy + 39'({i_cell_y, 1'b0});
                end
            end else begin
                r_iz <= r_iz + cgo_pkg::ZBits'(1);
                r_cz <= r_cz + 39'({i_cell_z, 1'b0});
            end
        end
        // Geometry pipeline.
        s1_fx <= fold(r_ax, r_cx, w_lx);
        s1_fy <= fold(r_ay, r_cy, w_ly);
        s1_fz <= fold(r_az, r_cz, w_lz);
        s1_cell <= r_cell;
        s2_ok <= (s1_fx < 42'(w_r2)) && (s1_fy < 42'(w_r2)) && (s1_fz < 42'(w_r2));
        s2_sx <= 64'(s1_fx[31:0]) * 64'(s1_fx[31:0]);
        s2_sy <= 64'(s1_fy[31:0]) * 64'(s1_fy[31:0]);
        s2_sz <= 64'(s1_fz[31:0]) * 64'(s1_fz[31:0]);
        s2_cell <= s1_cell;
        s3_hit <= s2_ok && (w_sum <= 66'(w_lim));
        s3_cell <= s2_cell;
        s4_hit <= s3_hit; s4_cell <= s3_cell;
        s5_hit <= s4_hit; s5_cell <= s4_cell;
        if (i_cmd.write_en) begin
            r_unf <= r_unf | n_unf;
            r_ovf <= r_ovf | n_ovf;
            if (r_kind == cgo_pkg::K_REBUILD && w_cnt == '0) r_count <= r_count + 13'd1;
            if (w_qhit) begin
                o_cell_count <= 8'(w_cnt);
                o_cell_is_cavity <= w_flag;
            end
        end
        if (i_cmd.finish) begin
            o_underflow <= r_unf;
            o_overflow  <= r_ovf;
        end
    end

    logic [12:0] w_next_total;
    always_comb begin
        case (r_kind)
            cgo_pkg::K_CLEAR:   w_next_total = '0;
            cgo_pkg::K_RESTORE: w_next_total = r_saved_total;
            cgo_pkg::K_REBUILD: w_next_total = r_count;
            default:            w_next_total = r_total;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) o_cavity_count <= w_next_total;
    end
endmodule

### src/cavity_grid_occupancy.sv
// Top level of the cavity grid occupancy block: APB registers, controller, datapath.
// Depends on cgo_pkg, cgo_if, cgo_ctrl, cgo_dp, cgo_ram.
//
//  Channel  Direction  Payload
//  i_req    in         kind, atom_x/y/z, query_cell
//  o_rsp    out        underflow/overflow error, cavity_count, cell_count, cell_is_cavity
//  APB      in         seven configuration registers at 4*i
//
// Every request sweeps all 4096 cells, one per cycle through a five-stage pipeline,
// then drains the pipeline and loads the result register.
// After reset a clearing pass over all 4096 cells zeroes both memories; no request is
// taken until it ends. A result waits in its register until taken.
module cavity_grid_occupancy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgo_req_if.sink     i_req,
    cgo_rsp_if.source   o_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic signed [31:0] r_box_x, r_box_y, r_box_z;
    logic [30:0] r_cell_x, r_cell_y, r_cell_z, r_cutoff;
    logic [2:0] w_idx;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x <= '0; r_box_y <= '0; r_box_z <= '0;
            r_cell_x <= 31'd65536; r_cell_y <= 31'd65536; r_cell_z <= 31'd65536;
            r_cutoff <= 31'd163840;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                cgo_pkg::R_BOX_X:  r_box_x <= pwdata;
                cgo_pkg::R_BOX_Y:  r_box_y <= pwdata;
                cgo_pkg::R_BOX_Z:  r_box_z <= pwdata;
                cgo_pkg::R_CELL_X: r_cell_x <= pwdata[30:0];
                cgo_pkg::R_CELL_Y: r_cell_y <= pwdata[30:0];
                cgo_pkg::R_CELL_Z: r_cell_z <= pwdata[30:0];
                cgo_pkg::R_CUTOFF: r_cutoff <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cgo_pkg::R_BOX_X:  prdata = r_box_x;
            cgo_pkg::R_BOX_Y:  prdata = r_box_y;
            cgo_pkg::R_BOX_Z:  prdata = r_box_z;
            cgo_pkg::R_CELL_X: prdata = {1'b0, r_cell_x};
            cgo_pkg::R_CELL_Y: prdata = {1'b0, r_cell_y};
            cgo_pkg::R_CELL_Z: prdata = {1'b0, r_cell_z};
            cgo_pkg::R_CUTOFF: prdata = {1'b0, r_cutoff};
            default:           prdata = '0;
        endcase
    end

    cgo_pkg::t_cmd    w_cmd;
    cgo_pkg::t_status w_status;
    logic w_init_done;

    cgo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_init_done(w_init_done), .i_status(w_status), .o_cmd(w_cmd));

    cgo_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_status(w_status),
        .o_init_done(w_init_done),
        .i_kind(i_req.kind), .i_atom_x(i_req.atom_x), .i_atom_y(i_req.atom_y),
        .i_atom_z(i_req.atom_z), .i_query_cell(i_req.query_cell),
        .i_box_x(r_box_x), .i_box_y(r_box_y), .i_box_z(r_box_z),
        .i_cell_x(r_cell_x), .i_cell_y(r_cell_y), .i_cell_z(r_cell_z),
        .i_cutoff(r_cutoff),
        .o_underflow(o_rsp.underflow_error), .o_overflow(o_rsp.overflow_error),
        .o_cavity_count(o_rsp.cavity_count), .o_cell_count(o_rsp.cell_count),
        .o_cell_is_cavity(o_rsp.cell_is_cavity));
endmodule
